// File: hw/rtl/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg: shared definitions for the command frame checker
// Frame constants, error codes and the item and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0] HDR_MARK    = 8'hAB;
    localparam int         MIN_FRAME   = 8;
    localparam int         FRAME_EXTRA = 6;
    localparam int         SUM_OFFSET  = 4;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_HEADER    = 3'd2;
    localparam logic [2:0] ERR_LENGTH    = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        frame_ok;
        logic [2:0]  error_code;
        logic [7:0]  frame_tag;
        logic [15:0] command_id;
        logic [15:0] length_field;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/cfc_in_if.sv
// ----------------------------------------------------------------------------
// cfc_in_if: frame byte channel
// Valid/ready channel carrying one frame byte and its last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cfc_out_if.sv
// ----------------------------------------------------------------------------
// cfc_out_if: frame verdict channel
// Valid/ready channel carrying one verdict with the captured frame fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfc_out_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [7:0]  frame_tag;
    logic [15:0] command_id;
    logic [15:0] length_field;

    modport source (output valid, output frame_ok, output error_code, output frame_tag,
                    output command_id, output length_field, input ready);
    modport sink   (input valid, input frame_ok, input error_code, input frame_tag,
                    input command_id, input length_field, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cfc_in_stage.sv
// ----------------------------------------------------------------------------
// cfc_in_stage: input register
// Holds one incoming byte request until the checker core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    cfc_in_if.sink             i_in,
    input  wire logic          i_advance,
    output cfc_pkg::t_in_item  o_item,
    output logic               o_valid
);

    logic              r_valid;
    logic              n_valid;
    cfc_pkg::t_in_item r_item;

    assign i_in.ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_in.valid && i_in.ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.byte_value <= i_in.byte_value;
            r_item.last_byte  <= i_in.last_byte;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// File: hw/rtl/cfc_core.sv
// ----------------------------------------------------------------------------
// cfc_core: frame checker state and verdict
// Captures header fields, accumulates the checksum and forms the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire cfc_pkg::t_in_item  i_item,
    input  wire logic               i_out_free,
    output logic                    o_advance,
    output logic                    o_res_valid,
    output cfc_pkg::t_result        o_result
);

    logic [cfc_pkg::COUNT_W-1:0] r_count,    n_count;
    logic [7:0]                  r_sum,      n_sum;
    logic                        r_hdr_ok,   n_hdr_ok;
    logic [15:0]                 r_len,      n_len;
    logic                        r_csum_ok,  n_csum_ok;
    logic [7:0]                  r_tag,      n_tag;
    logic [15:0]                 r_cmd,      n_cmd;

    logic [cfc_pkg::COUNT_W-1:0] sum_pos;
    logic [cfc_pkg::COUNT_W:0]   frame_size;
    logic [cfc_pkg::COUNT_W:0]   expect_size;
    logic [7:0]                  b;
    logic [2:0]                  code;

    assign b           = i_item.byte_value;
    assign o_advance   = i_valid && (!i_item.last_byte || i_out_free);
    assign o_res_valid = o_advance && i_item.last_byte;

    always_comb begin
        n_hdr_ok  = r_hdr_ok;
        n_tag     = r_tag;
        n_len     = r_len;
        n_cmd     = r_cmd;
        n_sum     = r_sum;
        n_csum_ok = r_csum_ok;

        unique case (r_count)
            17'd0:   n_hdr_ok = (b == cfc_pkg::HDR_MARK);
            17'd1:   n_tag    = b;
            17'd2:   n_len    = {r_len[15:8], b};
            17'd3:   n_len    = {b, r_len[7:0]};
            17'd4:   n_cmd    = {r_cmd[15:8], b};
            17'd5:   n_cmd    = {b, r_cmd[7:0]};
            default: ;
        endcase

        // checksum sits right after the payload, at length + 4
        sum_pos = {1'b0, n_len} + cfc_pkg::COUNT_W'(cfc_pkg::SUM_OFFSET);
        priority if (r_count < cfc_pkg::COUNT_W'(cfc_pkg::SUM_OFFSET) || r_count < sum_pos) begin
            n_sum = r_sum + b;
        end else if (r_count == sum_pos) begin
            n_csum_ok = (b == 8'(9'h100 - {1'b0, r_sum}));
        end else begin
            // past the checksum byte: hold
            n_sum = r_sum;
        end

        n_count = (r_count != cfc_pkg::COUNT_MAX) ? r_count + 1'b1 : r_count;

        frame_size  = {1'b0, r_count} + 1'b1;
        expect_size = {2'b00, n_len} + (cfc_pkg::COUNT_W+1)'(cfc_pkg::FRAME_EXTRA);
        priority if (frame_size < (cfc_pkg::COUNT_W+1)'(cfc_pkg::MIN_FRAME)) begin
            code = cfc_pkg::ERR_SHORT;
        end else if (!n_hdr_ok) begin
            code = cfc_pkg::ERR_HEADER;
        end else if (frame_size != expect_size) begin
            code = cfc_pkg::ERR_LENGTH;
        end else if (!n_csum_ok) begin
            code = cfc_pkg::ERR_CHECKSUM;
        end else begin
            code = cfc_pkg::ERR_OK;
        end

        o_result.frame_ok     = (code == cfc_pkg::ERR_OK);
        o_result.error_code   = code;
        o_result.frame_tag    = n_tag;
        o_result.command_id   = n_cmd;
        o_result.length_field = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            // clear on reset, and for the next frame once the verdict is loaded into the result register
            r_count   <= '0;
            r_sum     <= '0;
            r_hdr_ok  <= 1'b0;
            r_len     <= '0;
            r_csum_ok <= 1'b0;
            r_tag     <= '0;
            r_cmd     <= '0;
        end else if (o_advance) begin
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_hdr_ok  <= n_hdr_ok;
            r_len     <= n_len;
            r_csum_ok <= n_csum_ok;
            r_tag     <= n_tag;
            r_cmd     <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cfc_out_stage.sv
// ----------------------------------------------------------------------------
// cfc_out_stage: result register
// Holds one verdict request until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire cfc_pkg::t_result  i_result,
    cfc_out_if.source              o_out,
    output logic                   o_free
);

    logic             r_valid;
    logic             n_valid;
    cfc_pkg::t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.frame_ok     = r_result.frame_ok;
    assign o_out.error_code   = r_result.error_code;
    assign o_out.frame_tag    = r_result.frame_tag;
    assign o_out.command_id   = r_result.command_id;
    assign o_out.length_field = r_result.length_field;

endmodule

`default_nettype wire

// File: hw/rtl/command_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// command_frame_checker_unit: command frame checker
// Checks header, length and checksum of a byte-serial command frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle, back to back, with no gaps
// required between bytes or frames. Each byte passes through an input
// register and is then folded into the frame state; on the byte marked
// last, the verdict and the captured tag, length and command id are
// registered into the result register, so a verdict is valid on the cycle
// after the core takes its last byte. The result register and the input
// register decouple the two sides: bytes keep flowing while a verdict waits,
// and only a last byte stalls when an earlier verdict has not been taken.
// Error codes: 0 ok, 1 too short, 2 bad header, 3 length mismatch,
// 4 checksum mismatch, checked in that order.
`default_nettype none

module command_frame_checker_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cfc_in_if.sink     i_in,
    cfc_out_if.source  o_out
);

    cfc_pkg::t_in_item in_item;
    logic              in_valid;
    logic              core_advance;
    logic              res_valid;
    logic              out_free;
    cfc_pkg::t_result  core_result;

    cfc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (core_advance),
        .o_item    (in_item),
        .o_valid   (in_valid)
    );

    cfc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_item      (in_item),
        .i_out_free  (out_free),
        .o_advance   (core_advance),
        .o_res_valid (res_valid),
        .o_result    (core_result)
    );

    cfc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (core_result),
        .o_out    (o_out),
        .o_free   (out_free)
    );

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("verdict valid right after reset");

    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_advance && in_item.last_byte) |=> o_out.valid)
        else $error("last byte taken without a verdict");

    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.frame_ok == (o_out.error_code == cfc_pkg::ERR_OK)))
        else $error("frame_ok disagrees with error_code");

    a_stalled_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !core_advance) |=> in_valid)
        else $error("stalled byte dropped from input register");

endmodule

`default_nettype wire

// File: bench/command_frame_checker_unit_tb.sv
// ----------------------------------------------------------------------------
// command_frame_checker_unit_tb: command frame checker testbench
// Sends directed and random command frames, byte by byte, through the frame
// byte channel with random gaps and verdict stalls. A predictor follows every
// accepted byte, queues the verdict it expects on each last byte, and checks
// every verdict field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_frame_checker_unit_tb;

    localparam int unsigned STALL_LIMIT  = 400;
    localparam int unsigned RANDOM_BYTES = 1900;

    // Predicts frame verdicts and checks the ones the block returns.
    class frame_verdict_board;
        logic [cfc_pkg::COUNT_W-1:0] byte_pos;
        logic [7:0]                  sum_acc;
        bit                          hdr_ok;
        bit                          sum_ok;
        logic [7:0]                  tag;
        logic [15:0]                 len_word;
        logic [15:0]                 cmd_word;
        cfc_pkg::t_result            pending_verdicts[$];
        int unsigned                 fail_count;
        int unsigned                 verdict_count;

        function new();
            clear_frame();
            fail_count    = 0;
            verdict_count = 0;
        endfunction

        function void clear_frame();
            byte_pos = '0;
            sum_acc  = '0;
            hdr_ok   = 1'b0;
            sum_ok   = 1'b0;
            tag      = '0;
            len_word = '0;
            cmd_word = '0;
        endfunction

        function void note_byte(logic [7:0] value, logic last);
            int unsigned      pos;
            int unsigned      sum_pos;
            int unsigned      size;
            cfc_pkg::t_result verdict;
            pos = byte_pos;
            case (pos)
                0: hdr_ok = (value == cfc_pkg::HDR_MARK);
                1: tag = value;
                2: len_word[7:0] = value;
                3: len_word[15:8] = value;
                4: cmd_word[7:0] = value;
                5: cmd_word[15:8] = value;
                default: ;
            endcase
            sum_pos = len_word + cfc_pkg::SUM_OFFSET;
            if (pos < cfc_pkg::SUM_OFFSET || pos < sum_pos) begin
                sum_acc = sum_acc + value;
            end else if (pos == sum_pos) begin
                // 0x100 minus the sum, modulo 256
                sum_ok = (value == 8'h00 - sum_acc);
            end
            if (byte_pos != cfc_pkg::COUNT_MAX) begin
                byte_pos++;
            end
            if (last) begin
                size = pos + 1;
                if (size < cfc_pkg::MIN_FRAME) begin
                    verdict.error_code = cfc_pkg::ERR_SHORT;
                end else if (!hdr_ok) begin
                    verdict.error_code = cfc_pkg::ERR_HEADER;
                end else if (size != len_word + cfc_pkg::FRAME_EXTRA) begin
                    verdict.error_code = cfc_pkg::ERR_LENGTH;
                end else if (!sum_ok) begin
                    verdict.error_code = cfc_pkg::ERR_CHECKSUM;
                end else begin
                    verdict.error_code = cfc_pkg::ERR_OK;
                end
                verdict.frame_ok     = (verdict.error_code == cfc_pkg::ERR_OK);
                verdict.frame_tag    = tag;
                verdict.command_id   = cmd_word;
                verdict.length_field = len_word;
                pending_verdicts.push_back(verdict);
                clear_frame();
            end
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("%0t ns verdict %0d: %s got 0x%0h, expected 0x%0h",
                     $time, verdict_count, what, got, want);
            fail_count++;
        endtask

        task check_verdict(cfc_pkg::t_result got);
            cfc_pkg::t_result want;
            verdict_count++;
            if (pending_verdicts.size() == 0) begin
                report("verdict with no frame pending, code", got.error_code, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.frame_ok !== want.frame_ok)
                    report("frame_ok", got.frame_ok, want.frame_ok);
                if (got.error_code !== want.error_code)
                    report("error_code", got.error_code, want.error_code);
                if (got.frame_tag !== want.frame_tag)
                    report("frame_tag", got.frame_tag, want.frame_tag);
                if (got.command_id !== want.command_id)
                    report("command_id", got.command_id, want.command_id);
                if (got.length_field !== want.length_field)
                    report("length_field", got.length_field, want.length_field);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    cfc_in_if  in_if ();
    cfc_out_if out_if ();

    command_frame_checker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    frame_verdict_board board;
    logic [7:0]         frame_buf[$];
    int unsigned        idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Monitor both channels and watch for a hung block.
    always @(posedge i_clk) begin
        cfc_pkg::t_result got;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.frame_ok     = out_if.frame_ok;
                got.error_code   = out_if.error_code;
                got.frame_tag    = out_if.frame_tag;
                got.command_id   = out_if.command_id;
                got.length_field = out_if.length_field;
                board.check_verdict(got);
            end
            if (in_if.valid && in_if.ready) begin
                board.note_byte(in_if.byte_value, in_if.last_byte);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no request moved for %0d cycles", $time, idle_cycles);
                $display("command_frame_checker_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // Verdict side: stall a random number of cycles before each verdict,
    // with calm stretches where ready stays high.
    initial begin
        int unsigned run_left;
        bit          calm;
        int unsigned stall;
        run_left = 0;
        calm     = 1'b0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (run_left == 0) begin
                run_left = $urandom_range(5, 30);
                calm     = ($urandom_range(0, 3) == 0);
            end
            run_left--;
            stall = calm ? 0 : $urandom_range(0, 9);
            repeat (stall) begin
                out_if.ready <= 1'b0;
                @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom_range(0, 1);
        if (r < 80) return $urandom_range(2, 20);
        return $urandom_range(21, 300);
    endfunction

    // Fill frame_buf with a frame: header, fields, random payload, correct
    // checksum and one trailing byte; well formed only for a length of 2 or more.
    function automatic void build_frame(input int unsigned len, input logic [7:0] tag,
                                        input logic [15:0] cmd);
        logic [7:0] acc;
        frame_buf.delete();
        frame_buf.push_back(cfc_pkg::HDR_MARK);
        frame_buf.push_back(tag);
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(len[15:8]);
        frame_buf.push_back(cmd[7:0]);
        frame_buf.push_back(cmd[15:8]);
        while (frame_buf.size() < len + cfc_pkg::FRAME_EXTRA) begin
            frame_buf.push_back(8'($urandom));
        end
        while (frame_buf.size() > len + cfc_pkg::FRAME_EXTRA) begin
            void'(frame_buf.pop_back());
        end
        acc = '0;
        for (int i = 0; i < len + cfc_pkg::SUM_OFFSET; i++) begin
            acc = acc + frame_buf[i];
        end
        frame_buf[len + cfc_pkg::SUM_OFFSET] = 8'h00 - acc;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic last,
                             input int unsigned gap);
        repeat (gap) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.byte_value <= value;
        in_if.last_byte  <= last;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_frame(input bit calm);
        int unsigned gap;
        for (int i = 0; i < frame_buf.size(); i++) begin
            gap = calm ? 0 : $urandom_range(0, 9);
            send_byte(frame_buf[i], i == frame_buf.size() - 1, gap);
        end
    endtask

    initial begin
        int unsigned random_bytes;
        int unsigned kind;
        int unsigned keep;
        board        = new();
        idle_cycles  = 0;
        random_bytes = 0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.byte_value = '0;
        in_if.last_byte  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // good minimal frame with all-ones tag and command id and a zero trailing byte
        build_frame(2, 8'hFF, 16'hFFFF);
        frame_buf[7] = 8'h00;
        send_frame(1'b0);
        // one-byte frame: too short, fields read as zero
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame(1'b0);
        // wrong header
        build_frame(2, 8'h00, 16'h0000);
        frame_buf[0] = 8'h00;
        send_frame(1'b0);
        // checksum off by one bit
        build_frame(2, 8'h5A, 16'hA55A);
        frame_buf[6] ^= 8'h80;
        send_frame(1'b0);

        while (random_bytes < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            build_frame(pick_len(), 8'($urandom), 16'($urandom));
            if (kind < 45) begin
                // keep the frame well formed
            end else if (kind < 55) begin
                // checksum sits just before the trailing byte
                frame_buf[frame_buf.size() - 2] ^= 8'($urandom_range(1, 255));
            end else if (kind < 65) begin
                frame_buf[0] = cfc_pkg::HDR_MARK ^ 8'($urandom_range(1, 255));
            end else if (kind < 75) begin
                keep = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > keep) void'(frame_buf.pop_back());
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom));
            end else begin
                frame_buf.delete();
                repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 1) frame_buf[0] = cfc_pkg::HDR_MARK;
            end
            random_bytes += frame_buf.size();
            send_frame($urandom_range(0, 4) == 0);
        end
        in_if.valid <= 1'b0;

        // let the monitor note the final byte before draining
        @(posedge i_clk);
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.fail_count == 0) begin
            $display("command_frame_checker_unit_tb: PASS");
        end else begin
            $display("command_frame_checker_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cfc_pkg.sv
hw/rtl/cfc_in_if.sv
hw/rtl/cfc_out_if.sv
hw/rtl/cfc_in_stage.sv
hw/rtl/cfc_core.sv
hw/rtl/cfc_out_stage.sv
hw/rtl/command_frame_checker_unit.sv
bench/command_frame_checker_unit_tb.sv
